@@ hdl/bbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared constants and types for the bilinear Bayer demosaic unit.
// ----------------------------------------------------------------------------
package bbd_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 4096;
   localparam int PIXEL_BITS_DEFAULT = 10;

   localparam int CSR_BITS   = 13;
   localparam int ROW_BITS   = 13;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_SIZE   = 4;

   localparam logic [CSR_BITS-1:0] WIDTH_RESET  = 13'd3264;
   localparam logic [CSR_BITS-1:0] HEIGHT_RESET = 13'd2448;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Position information for the pixel that the window centre will hold
   typedef struct packed {
      logic emit;
      logic top_sel;
      logic in_range;
      logic y_top;
      logic y_bot;
      logic x_lft;
      logic x_rgt;
      logic y_odd;
      logic x_odd;
      logic frame_end;
   } pos_type;

endpackage

@@ hdl/bbd_line_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_line_store
// Two row banks of samples; both read at one column, one bank written.
// ----------------------------------------------------------------------------
module bbd_line_store #(
   parameter int MAX_WIDTH  = bbd_pkg::MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS = bbd_pkg::PIXEL_BITS_DEFAULT,
   parameter int AW         = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [AW-1:0]         addr,
   input  logic                  wr_en,
   input  logic                  wr_bank,
   input  logic [PIXEL_BITS-1:0] wr_data,
   output logic [PIXEL_BITS-1:0] rd_bank0,
   output logic [PIXEL_BITS-1:0] rd_bank1
);

   logic [PIXEL_BITS-1:0] bank0_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] bank1_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] rd0_ff;
   logic [PIXEL_BITS-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en && !wr_bank) begin
         bank0_mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd0_ff <= bank0_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_bank) begin
         bank1_mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd1_ff <= bank1_mem[addr];
      end
   end

   assign rd_bank0 = rd0_ff;
   assign rd_bank1 = rd1_ff;

endmodule

@@ hdl/bbd_scan_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_scan_ctrl
// Frame size registers, raster counters and the input stage register.
// ----------------------------------------------------------------------------
module bbd_scan_ctrl #(
   parameter int MAX_WIDTH  = bbd_pkg::MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS = bbd_pkg::PIXEL_BITS_DEFAULT,
   parameter int AW         = $clog2(MAX_WIDTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          op,
   input  logic [PIXEL_BITS-1:0]         sample,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [bbd_pkg::CSR_BITS-1:0]  csr_wdata,
   input  logic                          stage_adv,
   output logic                          mem_rd_en,
   output logic [AW-1:0]                 mem_addr,
   output logic                          mem_wr_en,
   output logic                          mem_wr_bank,
   output logic                          stage_valid,
   output bbd_pkg::pos_type              stage_pos,
   output logic [PIXEL_BITS-1:0]         stage_cur
);

   localparam int CW   = $clog2(MAX_WIDTH + 1);
   localparam int RB   = bbd_pkg::ROW_BITS;
   localparam int WTOP = MAX_WIDTH - (MAX_WIDTH % 2);

   logic [bbd_pkg::CSR_BITS-1:0] width_ff, width_in;
   logic [bbd_pkg::CSR_BITS-1:0] height_ff, height_in;
   logic [RB-1:0]                row_ff, row_in;
   logic [CW-1:0]                col_ff, col_in;
   logic                         drain_ff, drain_in;
   logic                         valid_ff, valid_in;
   bbd_pkg::pos_type             pos_ff, pos_in;
   logic [PIXEL_BITS-1:0]        cur_ff, cur_in;

   logic [15:0]   wt;
   logic [RB-1:0] ht;
   logic [CW-1:0] w_eff;
   logic [RB-1:0] h_eff;
   logic [RB-1:0] y;
   logic [CW-1:0] x;
   logic [CW-1:0] col_inc;
   logic [RB-1:0] row_inc;
   logic          item_go;
   logic          in_range;

   // Effective sizes: bit 0 cleared, then clamped
   always_comb begin
      wt = {3'b000, width_ff & 13'h1FFE};
      if (wt < 16'(bbd_pkg::MIN_SIZE)) begin
         wt = 16'(bbd_pkg::MIN_SIZE);
      end
      if (wt > 16'(WTOP)) begin
         wt = 16'(WTOP);
      end
      w_eff = wt[CW-1:0];
      ht = height_ff & 13'h1FFE;
      if (ht < RB'(bbd_pkg::MIN_SIZE)) begin
         ht = RB'(bbd_pkg::MIN_SIZE);
      end
      if (ht > RB'(bbd_pkg::MAX_HEIGHT)) begin
         ht = RB'(bbd_pkg::MAX_HEIGHT);
      end
      h_eff = ht;
   end

   assign item_go  = accept && (drain_ff || op == bbd_pkg::OP_PIXEL);
   assign in_range = col_ff < w_eff;
   assign col_inc  = col_ff + CW'(1);
   assign row_inc  = row_ff + RB'(1);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      drain_in  = drain_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      valid_in  = valid_ff;
      y         = '0;
      x         = '0;

      if (valid_ff && stage_adv) begin
         valid_in = 1'b0;
      end

      if (item_go) begin
         valid_in = 1'b1;
         if (!drain_ff) begin
            if (col_ff != '0) begin
               y = row_ff - RB'(1);
               x = col_ff - CW'(1);
            end else begin
               y = row_ff - RB'(2);
               x = w_eff - CW'(1);
            end
            pos_in.emit    = (row_ff >= RB'(2)) || (row_ff == RB'(1) && col_ff != '0);
            pos_in.top_sel = row_ff[0];
            cur_in         = sample;
            if (col_inc == w_eff) begin
               col_in = '0;
               row_in = row_inc;
               if (row_inc == h_eff) begin
                  drain_in = 1'b1;
                  row_in   = h_eff - RB'(1);
               end
            end else begin
               col_in = col_inc;
            end
         end else begin
            if (col_ff == '0) begin
               y = h_eff - RB'(2);
               x = w_eff - CW'(1);
            end else begin
               y = h_eff - RB'(1);
               x = col_ff - CW'(1);
            end
            pos_in.emit    = 1'b1;
            pos_in.top_sel = 1'b0;
            cur_in         = '0;
            col_in         = col_inc;
         end
         pos_in.in_range  = in_range;
         pos_in.y_top     = (y == '0);
         pos_in.y_bot     = (y == h_eff - RB'(1));
         pos_in.x_lft     = (x == '0);
         pos_in.x_rgt     = (x == w_eff - CW'(1));
         pos_in.y_odd     = y[0];
         pos_in.x_odd     = x[0];
         pos_in.frame_end = pos_in.y_bot && pos_in.x_rgt;
         // last pixel of the frame: restart counters
         if (pos_in.frame_end) begin
            row_in   = '0;
            col_in   = '0;
            drain_in = 1'b0;
         end
      end

      if (csr_write_en) begin
         unique case (bbd_pkg::csr_index_type'(csr_index))
            bbd_pkg::CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            bbd_pkg::CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
         row_in   = '0;
         col_in   = '0;
         drain_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bbd_pkg::WIDTH_RESET;
         height_ff <= bbd_pkg::HEIGHT_RESET;
         row_ff    <= '0;
         col_ff    <= '0;
         drain_ff  <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         drain_ff  <= drain_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      cur_ff <= cur_in;
   end

   assign mem_rd_en   = item_go && in_range;
   assign mem_addr    = col_ff[AW-1:0];
   assign mem_wr_en   = accept && !drain_ff && op == bbd_pkg::OP_PIXEL;
   assign mem_wr_bank = row_ff[0];
   assign stage_valid = valid_ff;
   assign stage_pos   = pos_ff;
   assign stage_cur   = cur_ff;

endmodule

@@ hdl/bbd_interp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_interp
// 3x3 window, bilinear colour rules and the result register.
// ----------------------------------------------------------------------------
module bbd_interp #(
   parameter int PIXEL_BITS = bbd_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  stage_valid,
   input  bbd_pkg::pos_type      stage_pos,
   input  logic [PIXEL_BITS-1:0] stage_cur,
   input  logic [PIXEL_BITS-1:0] rd_bank0,
   input  logic [PIXEL_BITS-1:0] rd_bank1,
   output logic                  stage_adv,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIXEL_BITS-1:0] rsp_red,
   output logic [PIXEL_BITS-1:0] rsp_green,
   output logic [PIXEL_BITS-1:0] rsp_blue,
   output logic                  rsp_frame_end
);

   localparam int PB  = PIXEL_BITS;
   localparam int S3  = PB + 3;
   localparam int SW  = PB + 2;
   localparam logic [S3-1:0] K3 = S3'(((1 << S3) + 2) / 3);

   // window columns 1 and 2; column 0 is never read after a shift
   logic [PB-1:0] win1_ff [3];
   logic [PB-1:0] win2_ff [3];
   logic [PB-1:0] tl, t, tr, l, c, r, bl, b, br;
   logic [PB-1:0] new_top, new_mid;
   logic [PB-1:0] red_in, green_in, blue_in;
   logic [PB-1:0] red_ff, green_ff, blue_ff;
   logic          fe_ff, rsp_valid_ff, rsp_valid_in;
   logic          fire;
   logic [SW-1:0] s3;
   logic [SW+S3-1:0] prod3;
   logic [PB-1:0] g3;

   function automatic logic [PB-1:0] avg2(input logic [PB-1:0] p, input logic [PB-1:0] q);
      logic [PB:0] s;
      s = {1'b0, p} + {1'b0, q};
      return s[PB:1];
   endfunction

   function automatic logic [PB-1:0] avg4(input logic [PB-1:0] p, input logic [PB-1:0] q,
                                          input logic [PB-1:0] u, input logic [PB-1:0] v);
      logic [PB+1:0] s;
      s = {2'b00, p} + {2'b00, q} + {2'b00, u} + {2'b00, v};
      return s[PB+1:2];
   endfunction

   assign stage_adv = !rsp_valid_ff || rsp_ready;
   assign fire      = stage_valid && stage_adv;

   always_comb begin
      new_top = '0;
      new_mid = '0;
      if (stage_pos.in_range) begin
         new_top = stage_pos.top_sel ? rd_bank1 : rd_bank0;
         new_mid = stage_pos.top_sel ? rd_bank0 : rd_bank1;
      end
   end

   assign tl = win1_ff[0];
   assign t  = win2_ff[0];
   assign tr = new_top;
   assign l  = win1_ff[1];
   assign c  = win2_ff[1];
   assign r  = new_mid;
   assign bl = win1_ff[2];
   assign b  = win2_ff[2];
   assign br = stage_cur;

   // three-neighbour green on the side edges; divide by 3 via reciprocal
   always_comb begin
      s3 = {2'b00, t} + {2'b00, b} + (stage_pos.x_lft ? {2'b00, r} : {2'b00, l});
      prod3 = SW'(s3) * K3;
      g3 = prod3[S3+PB-1:S3];
   end

   always_comb begin
      red_in   = c;
      green_in = c;
      blue_in  = c;
      if (stage_pos.y_top && stage_pos.x_lft) begin
         red_in = c; green_in = avg2(r, b); blue_in = br;
      end else if (stage_pos.y_top && stage_pos.x_rgt) begin
         red_in = l; green_in = c; blue_in = b;
      end else if (stage_pos.y_bot && stage_pos.x_lft) begin
         red_in = t; green_in = c; blue_in = r;
      end else if (stage_pos.y_bot && stage_pos.x_rgt) begin
         red_in = tl; green_in = avg2(t, l); blue_in = c;
      end else if (stage_pos.y_top) begin
         if (stage_pos.x_odd) begin
            red_in = avg2(l, r); green_in = c; blue_in = b;
         end else begin
            red_in = c; green_in = avg2(b, r); blue_in = avg2(bl, br);
         end
      end else if (stage_pos.y_bot) begin
         if (stage_pos.x_odd) begin
            red_in = avg2(tl, tr); green_in = avg2(l, r); blue_in = c;
         end else begin
            red_in = t; green_in = c; blue_in = r;
         end
      end else if (stage_pos.x_lft) begin
         if (stage_pos.y_odd) begin
            red_in = avg2(t, b); green_in = c; blue_in = r;
         end else begin
            red_in = c; green_in = g3; blue_in = avg2(tr, br);
         end
      end else if (stage_pos.x_rgt) begin
         if (stage_pos.y_odd) begin
            red_in = avg2(tl, bl); green_in = g3; blue_in = c;
         end else begin
            red_in = l; green_in = c; blue_in = avg2(t, b);
         end
      end else if (!stage_pos.y_odd && !stage_pos.x_odd) begin
         red_in = c; green_in = avg4(t, b, l, r); blue_in = avg4(tl, tr, bl, br);
      end else if (!stage_pos.y_odd) begin
         red_in = avg2(l, r); green_in = c; blue_in = avg2(t, b);
      end else if (!stage_pos.x_odd) begin
         red_in = avg2(t, b); green_in = c; blue_in = avg2(l, r);
      end else begin
         red_in = avg4(tl, tr, bl, br); green_in = avg4(t, b, l, r); blue_in = c;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = stage_pos.emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            win1_ff[i] <= '0;
            win2_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            win1_ff[0] <= t;
            win1_ff[1] <= c;
            win1_ff[2] <= b;
            win2_ff[0] <= tr;
            win2_ff[1] <= r;
            win2_ff[2] <= br;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         fe_ff    <= stage_pos.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_frame_end = fe_ff;

endmodule

@@ hdl/bayer_bilinear_demosaic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_unit
// Bilinear demosaic of an RGGB Bayer raster stream, one pixel per clock.
// ----------------------------------------------------------------------------
// One item is taken every clock while the result register is free or being
// drained. Each item passes the line store read (both row banks read at the
// current column) into the stage register, then the window shift and colour
// rules into the result register, where it sits. The result for pixel n leaves
// with sample n + width + 1; after the last sample, width + 1 flush items
// (op = 1, or further samples, which are discarded) drain the last row and
// frame_end marks the final pixel. The user writes frame sizes through the csr
// port only while idle, unenforced by the block; a write restarts the frame.
// The line store holds 2 x MAX_WIDTH samples and needs no clearing after reset.
module bayer_bilinear_demosaic_unit #(
   parameter int MAX_WIDTH  = bbd_pkg::MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS = bbd_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [PIXEL_BITS-1:0]         req_raw_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [PIXEL_BITS-1:0]         rsp_red,
   output logic [PIXEL_BITS-1:0]         rsp_green,
   output logic [PIXEL_BITS-1:0]         rsp_blue,
   output logic                          rsp_frame_end,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [bbd_pkg::CSR_BITS-1:0]  csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic                  accept;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_addr;
   logic                  mem_wr_en;
   logic                  mem_wr_bank;
   logic [PIXEL_BITS-1:0] rd_bank0;
   logic [PIXEL_BITS-1:0] rd_bank1;
   logic                  stage_valid;
   logic                  stage_adv;
   bbd_pkg::pos_type      stage_pos;
   logic [PIXEL_BITS-1:0] stage_cur;

   assign req_ready = !stage_valid || stage_adv;
   assign accept    = req_valid && req_ready;

   bbd_scan_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS),
      .AW         (AW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .op           (req_op),
      .sample       (req_raw_sample),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .stage_adv    (stage_adv),
      .mem_rd_en    (mem_rd_en),
      .mem_addr     (mem_addr),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_bank  (mem_wr_bank),
      .stage_valid  (stage_valid),
      .stage_pos    (stage_pos),
      .stage_cur    (stage_cur)
   );

   bbd_line_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS),
      .AW         (AW)
   ) u_lines (
      .clock    (clock),
      .rd_en    (mem_rd_en),
      .addr     (mem_addr),
      .wr_en    (mem_wr_en),
      .wr_bank  (mem_wr_bank),
      .wr_data  (req_raw_sample),
      .rd_bank0 (rd_bank0),
      .rd_bank1 (rd_bank1)
   );

   bbd_interp #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_interp (
      .clock         (clock),
      .reset         (reset),
      .stage_valid   (stage_valid),
      .stage_pos     (stage_pos),
      .stage_cur     (stage_cur),
      .rd_bank0      (rd_bank0),
      .rd_bank1      (rd_bank1),
      .stage_adv     (stage_adv),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_frame_end (rsp_frame_end)
   );

`ifndef SYNTHESIS
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid && !stage_adv |=> stage_valid && $stable(stage_pos))
      else $error("stalled stage lost its item");

   a_no_write_while_drain: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !stage_valid || stage_adv)
      else $error("line store written without a transfer");
`endif

endmodule

@@ verif/bayer_bilinear_demosaic_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_unit_tb
// Self-checking bench for the RGGB bilinear demosaic unit. A directed table
// runs a small white frame, flush and drain cases. Random frames of many
// sizes then follow, with aborted frames and out-of-range sizes. A
// behavioural colour predictor with its own line store and window supplies
// the expected pixels. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_unit_tb;

   typedef struct packed {
      logic [9:0] red;
      logic [9:0] green;
      logic [9:0] blue;
      logic       frame_end;
   } rgb_pix_type;

   typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_WHITE, EXP_WHITE_END} exp_kind_type;

   typedef struct packed {
      logic         op;
      logic [9:0]   smp;
      exp_kind_type kind;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = bbd_pkg::OP_PIXEL;
   logic [9:0]  req_raw_sample = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [9:0]  rsp_red, rsp_green, rsp_blue;
   logic        rsp_frame_end;
   logic        csr_write_en = 1'b0;
   logic        csr_index = bbd_pkg::CSR_FRAME_WIDTH;
   logic [12:0] csr_wdata = '0;

   bayer_bilinear_demosaic_unit u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---- colour predictor state ----
   logic [12:0] width_reg, height_reg;
   logic [9:0]  line_mem [8192];
   int unsigned win [3][3];
   int unsigned in_row, in_col;
   bit          draining;

   rgb_pix_type pixel_q[$];
   int          errors = 0;
   int          item_count = 0;
   int          burst_left = 0;
   bit          hold_req = 0;
   int          hold_left = 0;
   int          ready_mode = 0;
   int          mode_left = 0;

   function automatic int unsigned eff_width();
      int unsigned w = width_reg & 13'h1FFE;
      if (w < 4) w = 4;
      if (w > 4096) w = 4096;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      int unsigned h = height_reg & 13'h1FFE;
      if (h < 4) h = 4;
      if (h > 4096) h = 4096;
      return h;
   endfunction

   function automatic void restart_frame();
      in_row = 0;
      in_col = 0;
      draining = 0;
   endfunction

   function automatic void shift_window(int unsigned r, int unsigned c, int unsigned w,
                                        int unsigned cur, bit wr);
      int unsigned top_s = 0, mid_s = 0, a, b;
      if (c < w) begin
         a = ((r & 1) * 4096 + c) % 8192;
         b = (((r + 1) & 1) * 4096 + c) % 8192;
         top_s = line_mem[a];
         mid_s = line_mem[b];
         if (wr) line_mem[a] = cur[9:0];
      end else begin
         cur = 0;
      end
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = top_s;
      win[1][2] = mid_s;
      win[2][2] = cur & 10'h3FF;
   endfunction

   function automatic rgb_pix_type colour_at(int unsigned y, int unsigned x,
                                             int unsigned w, int unsigned h);
      int unsigned tl = win[0][0], t = win[0][1], tr = win[0][2];
      int unsigned l = win[1][0], c = win[1][1], r = win[1][2];
      int unsigned bl = win[2][0], b = win[2][1], br = win[2][2];
      int unsigned rv, gv, bv;
      bit top_e = (y == 0), bot_e = (y == h - 1), lft_e = (x == 0), rgt_e = (x == w - 1);
      bit oy = y[0], ox = x[0];
      rgb_pix_type px;
      if (top_e && lft_e) begin rv = c; gv = (r + b) / 2; bv = br; end
      else if (top_e && rgt_e) begin rv = l; gv = c; bv = b; end
      else if (bot_e && lft_e) begin rv = t; gv = c; bv = r; end
      else if (bot_e && rgt_e) begin rv = tl; gv = (t + l) / 2; bv = c; end
      else if (top_e) begin
         if (ox) begin rv = (l + r) / 2; gv = c; bv = b; end
         else begin rv = c; gv = (b + r) / 2; bv = (bl + br) / 2; end
      end else if (bot_e) begin
         if (ox) begin rv = (tl + tr) / 2; gv = (l + r) / 2; bv = c; end
         else begin rv = t; gv = c; bv = r; end
      end else if (lft_e) begin
         if (oy) begin rv = (t + b) / 2; gv = c; bv = r; end
         else begin rv = c; gv = (t + b + r) / 3; bv = (tr + br) / 2; end
      end else if (rgt_e) begin
         if (oy) begin rv = (tl + bl) / 2; gv = (t + b + l) / 3; bv = c; end
         else begin rv = l; gv = c; bv = (t + b) / 2; end
      end else if (!oy && !ox) begin
         rv = c; gv = (t + b + l + r) / 4; bv = (tl + tr + bl + br) / 4;
      end else if (!oy) begin
         rv = (l + r) / 2; gv = c; bv = (t + b) / 2;
      end else if (!ox) begin
         rv = (t + b) / 2; gv = c; bv = (l + r) / 2;
      end else begin
         rv = (tl + tr + bl + br) / 4; gv = (t + b + l + r) / 4; bv = c;
      end
      px.red = rv[9:0];
      px.green = gv[9:0];
      px.blue = bv[9:0];
      px.frame_end = (y == h - 1) && (x == w - 1);
      return px;
   endfunction

   // Advance the predictor by one transfer; has is set when a pixel leaves
   function automatic void demosaic_step(logic op, logic [9:0] s, output bit has,
                                         output rgb_pix_type px);
      int unsigned w = eff_width(), h = eff_height();
      int unsigned r, c, y, x;
      has = 0;
      px = '0;
      if (!draining) begin
         r = in_row;
         c = in_col;
         if (op == bbd_pkg::OP_FLUSH) return;
         if (r >= h || c >= w) begin restart_frame(); r = 0; c = 0; end
         shift_window(r, c, w, s, 1);
         has = (r >= 2) || (r == 1 && c >= 1);
         if (c >= 1) begin y = r - 1; x = c - 1; end
         else if (r >= 2) begin y = r - 2; x = w - 1; end
         else begin y = 0; x = 0; end
         c++;
         if (c == w) begin c = 0; r++; end
         if (r == h) begin draining = 1; c = 0; r = h - 1; end
         in_row = r;
         in_col = c;
         if (!has) return;
      end else begin
         c = in_col;
         if (c > w) c = w;
         shift_window(h, c, w, 0, 0);
         if (c == 0) begin y = h - 2; x = w - 1; end
         else begin y = h - 1; x = c - 1; end
         in_col = c + 1;
         has = 1;
      end
      px = colour_at(y, x, w, h);
      if (px.frame_end) restart_frame();
   endfunction

   task automatic report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // ---- result side: check and stall pattern ----
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_q.size() == 0) begin
            report_mismatch("pixel with nothing expected");
         end else begin
            rgb_pix_type want;
            want = pixel_q.pop_front();
            if (rsp_red !== want.red)
               report_mismatch($sformatf("red %0d want %0d", rsp_red, want.red));
            if (rsp_green !== want.green)
               report_mismatch($sformatf("green %0d want %0d", rsp_green, want.green));
            if (rsp_blue !== want.blue)
               report_mismatch($sformatf("blue %0d want %0d", rsp_blue, want.blue));
            if (rsp_frame_end !== want.frame_end)
               report_mismatch($sformatf("frame_end %0b want %0b", rsp_frame_end,
                                         want.frame_end));
         end
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_req) begin
         // long hold-off so the block fills and back-pressures its input
         hold_req = 0;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 80);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   // ---- request side ----
   task automatic push_item(logic op, logic [9:0] s, exp_kind_type kind = EXP_MODEL);
      bit has;
      rgb_pix_type px;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_raw_sample <= s;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      item_count++;
      demosaic_step(op, s, has, px);
      case (kind)
         EXP_MODEL: if (has) pixel_q.push_back(px);
         EXP_WHITE: pixel_q.push_back(rgb_pix_type'{10'h3FF, 10'h3FF, 10'h3FF, 1'b0});
         EXP_WHITE_END: pixel_q.push_back(rgb_pix_type'{10'h3FF, 10'h3FF, 10'h3FF, 1'b1});
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pixel_q.size() != 0) @(posedge clock);
      // let the pipeline settle before any register write
      repeat (10) @(posedge clock);
   endtask

   task automatic write_size(logic [12:0] w, logic [12:0] h);
      bit width_first = $urandom_range(0, 1);
      csr_write_en <= 1'b1;
      csr_index <= width_first ? bbd_pkg::CSR_FRAME_WIDTH : bbd_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= width_first ? w : h;
      @(posedge clock);
      if (width_first) width_reg = w; else height_reg = h;
      restart_frame();
      csr_index <= width_first ? bbd_pkg::CSR_FRAME_HEIGHT : bbd_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= width_first ? h : w;
      @(posedge clock);
      if (width_first) height_reg = h; else width_reg = w;
      restart_frame();
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [9:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 10'h000;
         1: return 10'h3FF;
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   // One frame; stop early at abort_at, pause for the receiver at pause_at
   task automatic run_frame(int abort_at, int pause_at);
      int unsigned w = eff_width(), h = eff_height();
      for (int k = 0; k < w * h; k++) begin
         if ($urandom_range(0, 19) == 0)
            push_item(bbd_pkg::OP_FLUSH, 10'($urandom_range(0, 1023)));
         if (k == abort_at) return;
         if (k == pause_at) wait_drained();
         push_item(bbd_pkg::OP_PIXEL, rand_sample());
      end
      for (int k = 0; k <= w; k++)
         push_item($urandom_range(0, 3) == 0 ? bbd_pkg::OP_PIXEL : bbd_pkg::OP_FLUSH,
                   rand_sample());
   endtask

   dir_row_type dir_rows[25] = '{
      '{bbd_pkg::OP_FLUSH, 10'h155, EXP_NONE},
      '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_NONE}, '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_NONE},
      '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_NONE}, '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_NONE},
      '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_NONE},
      '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_WHITE}, '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_WHITE},
      '{bbd_pkg::OP_FLUSH, 10'h000, EXP_NONE},
      '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_WHITE}, '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_WHITE},
      '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_WHITE}, '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_WHITE},
      '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_WHITE}, '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_WHITE},
      '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_WHITE}, '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_WHITE},
      '{bbd_pkg::OP_PIXEL, 10'h3FF, EXP_WHITE},
      // drain: a sample offered now is discarded
      '{bbd_pkg::OP_FLUSH, 10'h000, EXP_WHITE}, '{bbd_pkg::OP_PIXEL, 10'h000, EXP_WHITE},
      '{bbd_pkg::OP_FLUSH, 10'h2AA, EXP_WHITE}, '{bbd_pkg::OP_FLUSH, 10'h000, EXP_WHITE},
      '{bbd_pkg::OP_FLUSH, 10'h000, EXP_WHITE_END},
      '{bbd_pkg::OP_FLUSH, 10'h000, EXP_NONE},
      '{bbd_pkg::OP_PIXEL, 10'h000, EXP_MODEL}
   };

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [12:0] w, h;
      width_reg = bbd_pkg::WIDTH_RESET;
      height_reg = bbd_pkg::HEIGHT_RESET;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i, j]) win[i][j] = 0;
      restart_frame();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_size(13'd4, 13'd4);
      foreach (dir_rows[i]) push_item(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].kind);
      wait_drained();

      // size extremes: tiny values clamp up, odd values lose bit 0, oversized ones clamp down, the widest rows in part
      write_size(13'd1, 13'd0);
      run_frame(-1, -1);
      wait_drained();
      write_size(13'd4096, 13'd4);
      hold_req = 1;
      run_frame(400, 200);
      wait_drained();
      write_size(13'd5, 13'd8191);
      run_frame(120, -1);
      wait_drained();
      write_size(13'd8191, 13'd5);
      run_frame(200, -1);
      wait_drained();

      while (item_count < 1250) begin
         case ($urandom_range(0, 5))
            0: begin w = 13'($urandom_range(0, 7)); h = 13'($urandom_range(0, 7)); end
            1: begin w = 13'($urandom_range(4, 40)); h = 13'($urandom_range(4, 6)); end
            2: begin w = 13'($urandom_range(0, 8191)); h = 13'd4; end
            default: begin
               w = 13'(2 * $urandom_range(2, 10));
               h = 13'(2 * $urandom_range(2, 4));
            end
         endcase
         write_size(w, h);
         if (eff_width() > 64) begin
            run_frame($urandom_range(8, 120), -1);
         end else begin
            repeat ($urandom_range(1, 3))
               run_frame(($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : -1, -1);
         end
         if ($urandom_range(0, 7) == 0) hold_req = 1;
         wait_drained();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
